FILE: hdl/pce_pkg.sv
// Shared constants and types for the Pearson correlation engine.
package pce_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int MAX_ROWS         = 65536;
	localparam int RESULT_FRAC_BITS = 15;

	localparam int COUNT_W  = 17;
	localparam int SUM_W    = 33;
	localparam int SQ_W     = 47;
	localparam int CROSS_W  = 48;
	localparam int OPND_W   = 64;
	localparam int PROD_W   = 2 * OPND_W;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 40;
	localparam int RES_W    = RESULT_FRAC_BITS + 1;

	// Per-set sums handed from the accumulator to the result sequencer.
	typedef struct packed {
		logic [COUNT_W-1:0]        n;
		logic signed [SUM_W-1:0]   s1;
		logic signed [SUM_W-1:0]   s2;
		logic [SQ_W-1:0]           q1;
		logic [SQ_W-1:0]           q2;
		logic signed [CROSS_W-1:0] c;
	} sums_t;

	typedef struct packed {
		logic              start;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] p;
	} mul_rsp_t;

endpackage

FILE: hdl/pce_front.sv
// Accumulator front end: takes one sample pair per cycle while the queue is not full and hands finished sums on.
module pce_front import pce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_W-1:0]    s_axis_tdata,  // first_value[15:0], second_value[31:16]
	input  logic               s_axis_tlast,  // last_row
	output logic               push,
	output sums_t              push_data,
	input  logic               full
);

	logic signed [SAMPLE_BITS-1:0]   x, y;
	logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
	logic                            take, add_en;
	sums_t                           acc_q, nxt;

	assign x = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign y = $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
	assign xx = x * x;
	assign yy = y * y;
	assign xy = x * y;

	assign s_axis_tready = !full;
	assign take = s_axis_tvalid && s_axis_tready;
	// Pairs beyond the row limit are dropped, but the set still closes on last_row.
	assign add_en = acc_q.n < COUNT_W'(MAX_ROWS);

	always_comb begin
		nxt = acc_q;
		if (add_en) begin
			nxt.n  = acc_q.n + COUNT_W'(1);
			nxt.s1 = acc_q.s1 + SUM_W'(x);
			nxt.s2 = acc_q.s2 + SUM_W'(y);
			nxt.q1 = acc_q.q1 + SQ_W'($unsigned(xx));
			nxt.q2 = acc_q.q2 + SQ_W'($unsigned(yy));
			nxt.c  = acc_q.c + CROSS_W'(xy);
		end
	end

	assign push = take && s_axis_tlast;
	assign push_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			if (s_axis_tlast) begin
				acc_q <= '0;
			end else begin
				acc_q <= nxt;
			end
		end
	end

endmodule

FILE: hdl/pce_queue.sv
// Two-entry queue of finished sums between the accumulator and the sequencer.
module pce_queue import pce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  sums_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output sums_t pop_data
);

	sums_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/pce_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, full-width unsigned product.
module pce_mul import pce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [PROD_W-1:0] acc_q;
	logic [OPND_W-1:0] mcand_q;
	logic [6:0]        cnt_q;
	logic              busy_q, done_q;
	logic [OPND_W:0]   sum;

	assign sum = {1'b0, acc_q[PROD_W-1:OPND_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
	assign rsp.done = done_q;
	assign rsp.p = acc_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= {{OPND_W{1'b0}}, req.b};
			mcand_q <= req.a;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[OPND_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= 7'(OPND_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hdl/pce_back.sv
// Result sequencer: variances, covariance, division and square root, output register.
module pce_back import pce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sums_t             pop_data,
	output logic              pop,
	output mul_req_t          mreq,
	input  mul_rsp_t          mrsp,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata  // correlation[15:0], zero_variance[16], rows_seen[33:17]
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [2:0] OP_N_Q1  = 3'd0;
	localparam logic [2:0] OP_S1_S1 = 3'd1;
	localparam logic [2:0] OP_N_Q2  = 3'd2;
	localparam logic [2:0] OP_S2_S2 = 3'd3;
	localparam logic [2:0] OP_N_C   = 3'd4;
	localparam logic [2:0] OP_S1_S2 = 3'd5;
	localparam logic [2:0] OP_VAR   = 3'd6;
	localparam logic [2:0] OP_MAG   = 3'd7;

	localparam int DVD_W  = PROD_W + 2 * RESULT_FRAC_BITS + 2;
	localparam int DIV_RW = 125;
	localparam int QUO_W  = 2 * RESULT_FRAC_BITS + 3;
	localparam int ROOT_W = RESULT_FRAC_BITS + 2;
	localparam int ONE    = 1 << RESULT_FRAC_BITS;

	logic [2:0]          state_q, op_q;
	sums_t               e_q;
	logic                start_q, zero_q, neg_q;
	logic [OPND_W-1:0]   t_q, sxx_q, syy_q, mag_q, diff;
	logic [DIV_RW-1:0]   prod_q, rem_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [QUO_W-1:0]    quo_q;
	logic [7:0]          cnt_q;
	logic [ROOT_W-1:0]   root_q, trial, m_val;
	logic [4:0]          bit_q;
	logic [2*ROOT_W-1:0] trial_sq;
	logic [DIV_RW:0]     r2, rdiff;
	logic [RES_W-1:0]    corr, corr_q;
	logic                zv_q;
	logic [COUNT_W-1:0]  rows_q;

	assign pop = (state_q == ST_IDLE) && !empty;
	assign diff = t_q - mrsp.p[OPND_W-1:0];

	always_comb begin
		mreq.start = start_q;
		mreq.a = '0;
		mreq.b = '0;
		case (op_q)
			OP_N_Q1: begin
				mreq.a = OPND_W'(e_q.n);
				mreq.b = OPND_W'(e_q.q1);
			end
			OP_S1_S1: begin
				mreq.a = OPND_W'(e_q.s1);
				mreq.b = OPND_W'(e_q.s1);
			end
			OP_N_Q2: begin
				mreq.a = OPND_W'(e_q.n);
				mreq.b = OPND_W'(e_q.q2);
			end
			OP_S2_S2: begin
				mreq.a = OPND_W'(e_q.s2);
				mreq.b = OPND_W'(e_q.s2);
			end
			OP_N_C: begin
				mreq.a = OPND_W'(e_q.n);
				mreq.b = OPND_W'(e_q.c);
			end
			OP_S1_S2: begin
				mreq.a = OPND_W'(e_q.s1);
				mreq.b = OPND_W'(e_q.s2);
			end
			OP_VAR: begin
				mreq.a = sxx_q;
				mreq.b = syy_q;
			end
			OP_MAG: begin
				mreq.a = mag_q;
				mreq.b = mag_q;
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
			end
		endcase
	end

	// Restoring division step: the remainder always stays below the divisor.
	assign r2 = {rem_q, dvd_q[DVD_W-1]};
	assign rdiff = r2 - {1'b0, prod_q};

	assign trial = root_q | (ROOT_W'(1) << bit_q);
	assign trial_sq = trial * trial;

	// The largest odd value not above the root is 2m-1, so m rounds half away from zero.
	assign m_val = ROOT_W'(({1'b0, root_q} + (ROOT_W + 1)'(1)) >> 1);

	always_comb begin
		if (zero_q) begin
			corr = '0;
		end else if (!neg_q && m_val == ROOT_W'(ONE)) begin
			corr = RES_W'(ONE - 1);
		end else if (neg_q) begin
			corr = RES_W'(ROOT_W'(0) - m_val);
		end else begin
			corr = RES_W'(m_val);
		end
	end

	assign m_axis_tdata = {{(OUT_W - COUNT_W - 1 - RES_W){1'b0}}, rows_q, zv_q, corr_q};

	always_ff @(posedge clk) begin
		if (pop) begin
			e_q <= pop_data;
		end
		case (state_q)
			ST_MUL: begin
				if (mrsp.done) begin
					case (op_q)
						OP_N_Q1, OP_N_Q2, OP_N_C: t_q <= mrsp.p[OPND_W-1:0];
						OP_S1_S1: sxx_q <= diff;
						OP_S2_S2: syy_q <= diff;
						OP_S1_S2: begin
							neg_q <= diff[OPND_W-1];
							mag_q <= diff[OPND_W-1] ? OPND_W'(0) - diff : diff;
						end
						OP_VAR: prod_q <= mrsp.p[DIV_RW-1:0];
						OP_MAG: begin
							dvd_q <= {mrsp.p, {(DVD_W - PROD_W){1'b0}}};
							rem_q <= '0;
							quo_q <= '0;
						end
						default: t_q <= t_q;
					endcase
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], !rdiff[DIV_RW]};
				rem_q <= rdiff[DIV_RW] ? r2[DIV_RW-1:0] : rdiff[DIV_RW-1:0];
			end
			ST_SQRT: begin
				if (trial_sq <= (2 * ROOT_W)'(quo_q)) begin
					root_q <= trial;
				end
			end
			default: begin
				root_q <= root_q;
			end
		endcase
		if (state_q == ST_DIV && cnt_q == 8'd1) begin
			root_q <= '0;
		end
		if (state_q == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
			corr_q <= corr;
			zv_q   <= zero_q;
			rows_q <= e_q.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_N_Q1;
			start_q       <= 1'b0;
			zero_q        <= 1'b0;
			cnt_q         <= '0;
			bit_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						op_q    <= OP_N_Q1;
						start_q <= 1'b1;
						zero_q  <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mrsp.done) begin
						if (op_q == OP_MAG) begin
							cnt_q   <= 8'(DVD_W);
							state_q <= ST_DIV;
						end else if (op_q == OP_S1_S2 && (sxx_q == '0 || syy_q == '0)) begin
							zero_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							op_q    <= op_q + 3'd1;
							start_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 8'd1;
					if (cnt_q == 8'd1) begin
						bit_q   <= 5'(ROOT_W - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/pearson_correlation_engine.sv
// Top level of the Pearson correlation engine.
//
//   channel   direction  contents
//   s_axis    in         first_value, second_value in tdata; last_row in tlast
//   m_axis    out        correlation, zero_variance, rows_seen in tdata
//
// The accumulator takes one sample pair per cycle, limited only by the result queue.
// Each finished set in the sequencer takes eight products on the shared one-bit-per-cycle
// multiplier, 160 division steps, 17 square root steps and a write of the output register.
// A set with a zero variance stops after six products. Two finished sets can wait in the
// queue; when it is full the input stalls. Reset clears all sums and drops any set in
// progress.
module pearson_correlation_engine import pce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // first_value[15:0], second_value[31:16]
	input  logic             s_axis_tlast,  // last_row
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // correlation[15:0], zero_variance[16], rows_seen[33:17]
);

	logic     push, full, pop, empty;
	sums_t    push_data, pop_data;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	pce_front u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
		.push, .push_data, .full
	);

	pce_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .empty, .pop_data
	);

	pce_mul u_mul (
		.clk, .arst_n, .req(mreq), .rsp(mrsp)
	);

	pce_back u_back (
		.clk, .arst_n, .empty, .pop_data, .pop, .mreq, .mrsp,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
	);

endmodule

FILE: hdl/pce_checker.sv
// Port-level checks for the Pearson correlation engine and their binding.
module pce_checker import pce_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result request changed while stalled");

	a_zero_var: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("zero variance with nonzero correlation");

	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:17] != 17'd0
			&& m_axis_tdata[33:17] <= 17'(MAX_ROWS))
		else $error("row count out of range");

	// A set of one row never has variance.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33:17] == 17'd1 |-> m_axis_tdata[16])
		else $error("single-row set without zero variance flag");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:34] == '0)
		else $error("padding bits set");

endmodule

bind pearson_correlation_engine pce_checker u_pce_checker (.*);
